// ===== design/dew_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_pkg
// Shared types and arithmetic steps for the Dirac energy weighting pipeline.
// ----------------------------------------------------------------------------
package dew_pkg;

    localparam int DIV_STAGES  = 32;  // two quotient bits per stage
    localparam int SQRT_STAGES = 32;  // one root bit per stage

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [15:0] m;
        logic [63:0] x;
    } mul_out_t;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [63:0] q;
    } div_out_t;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [31:0] root;
    } sqrt_out_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [63:0] n;
    } div_st_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    // one restoring divide step: next dividend bit in, quotient bit out
    function automatic div_st_t div_step(div_st_t s, logic [15:0] m);
        div_st_t     r;
        logic [16:0] t;
        logic        qb;
        t  = {s.rem, s.n[63]};
        qb = (t >= {1'b0, m});
        if (qb) begin
            t = t - {1'b0, m};
        end
        r.rem = t[15:0];
        r.n   = {s.n[62:0], qb};
        return r;
    endfunction

    // one digit-by-digit square root step on a pair of radicand bits
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
        sqrt_st_t    r;
        logic [35:0] t;
        logic [35:0] trial;
        t     = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (t >= trial) begin
            t      = t - trial;
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.root = {s.root[30:0], 1'b0};
        end
        r.rem = t[33:0];
        return r;
    endfunction

endpackage

// ===== design/dew_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_mul
// Magnitudes, divisor floor and the product 4*d*d*|e|, in a register pipeline.
// ----------------------------------------------------------------------------
module dew_mul import dew_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] energy_sample,
    input  logic [15:0] dirac_sample,
    input  logic [14:0] magnitude_floor,
    output mul_out_t    out
);

    logic [31:0] emag;
    logic [15:0] dmag;
    logic [15:0] fl;

    logic        v1_reg, neg1_reg;
    logic [15:0] m1_reg;
    logic [15:0] dmag1_reg;
    logic [31:0] emag1_reg;
    logic [30:0] dsq_reg;
    logic [31:0] emag2_reg;
    logic        v2_reg, neg2_reg;
    logic [15:0] m2_reg;
    logic [61:0] prod;
    logic        v3_reg, neg3_reg;
    logic [15:0] m3_reg;
    logic [63:0] x3_reg;

    assign emag = energy_sample[31] ? (32'd0 - energy_sample) : energy_sample;
    assign dmag = dirac_sample[15] ? (16'd0 - dirac_sample) : dirac_sample;
    assign fl   = (magnitude_floor == 15'd0) ? 16'd1 : {1'b0, magnitude_floor};
    assign prod = 62'(dsq_reg) * 62'(emag2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg1_reg  <= dirac_sample[15];
            m1_reg    <= (dmag > fl) ? dmag : fl;
            dmag1_reg <= dmag;
            emag1_reg <= emag;
            neg2_reg  <= neg1_reg;
            m2_reg    <= m1_reg;
            dsq_reg   <= 31'(32'(dmag1_reg) * 32'(dmag1_reg));
            emag2_reg <= emag1_reg;
            neg3_reg  <= neg2_reg;
            m3_reg    <= m2_reg;
            x3_reg    <= {prod, 2'b00};
        end
    end

    assign out.valid = v3_reg;
    assign out.neg   = neg3_reg;
    assign out.m     = m3_reg;
    assign out.x     = x3_reg;

endmodule

// ===== design/dew_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_div
// Pipelined restoring divider, 64-bit dividend by 16-bit divisor.
// ----------------------------------------------------------------------------
module dew_div import dew_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  mul_out_t in,
    output div_out_t out
);

    logic        v_reg   [DIV_STAGES];
    logic        neg_reg [DIV_STAGES];
    logic [15:0] m_reg   [DIV_STAGES];
    div_st_t     st_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic        v_in, neg_in;
            logic [15:0] m_in;
            div_st_t     s_in, s_mid, s_out;

            if (k == 0) begin : g_first
                assign v_in     = in.valid;
                assign neg_in   = in.neg;
                assign m_in     = in.m;
                assign s_in.rem = 16'd0;
                assign s_in.n   = in.x;
            end else begin : g_next
                assign v_in   = v_reg[k-1];
                assign neg_in = neg_reg[k-1];
                assign m_in   = m_reg[k-1];
                assign s_in   = st_reg[k-1];
            end

            always_comb begin
                s_mid = div_step(s_in, m_in);
                s_out = div_step(s_mid, m_in);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (adv) begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    neg_reg[k] <= neg_in;
                    m_reg[k]   <= m_in;
                    st_reg[k]  <= s_out;
                end
            end
        end
    endgenerate

    assign out.valid = v_reg[DIV_STAGES-1];
    assign out.neg   = neg_reg[DIV_STAGES-1];
    assign out.q     = st_reg[DIV_STAGES-1].n;

endmodule

// ===== design/dew_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_sqrt
// Pipelined integer square root, 64-bit radicand to 32-bit truncated root.
// ----------------------------------------------------------------------------
module dew_sqrt import dew_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  div_out_t  in,
    output sqrt_out_t out
);

    logic        v_reg   [SQRT_STAGES];
    logic        neg_reg [SQRT_STAGES];
    logic [63:0] rad_reg [SQRT_STAGES];
    sqrt_st_t    st_reg  [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic        v_in, neg_in;
            logic [63:0] rad_in;
            sqrt_st_t    s_in, s_out;

            if (k == 0) begin : g_first
                assign v_in      = in.valid;
                assign neg_in    = in.neg;
                assign rad_in    = in.q;
                assign s_in.rem  = 34'd0;
                assign s_in.root = 32'd0;
            end else begin : g_next
                assign v_in   = v_reg[k-1];
                assign neg_in = neg_reg[k-1];
                assign rad_in = rad_reg[k-1];
                assign s_in   = st_reg[k-1];
            end

            assign s_out = sqrt_step(s_in, rad_in[63:62]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (adv) begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    neg_reg[k] <= neg_in;
                    rad_reg[k] <= {rad_in[61:0], 2'b00};
                    st_reg[k]  <= s_out;
                end
            end
        end
    endgenerate

    assign out.valid = v_reg[SQRT_STAGES-1];
    assign out.neg   = neg_reg[SQRT_STAGES-1];
    assign out.root  = st_reg[SQRT_STAGES-1].root;

endmodule

// ===== design/dirac_energy_weighting.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirac_energy_weighting
// Weights a Dirac sample by sqrt(|energy| / max(|dirac|, floor)), Q16.16 out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser                          | handshake
//  s_      | in  | [31:0] energy_sample, [47:32] dirac    | s_tvalid/s_tready
//  m_      | out | [31:0] weighted_sample; tuser saturated| m_tvalid/m_tready
//  cfg     | in  | cfg_wdata[14:0] magnitude_floor        | cfg_wen
//
//  One item per cycle unless the output stalls. Pipeline: 3 multiply stages, 32
//  divider stages (two quotient bits each), 32 root stages, 1 output register.
//  The whole pipe advances together; it holds while the output register is
//  full and not taken, so s_tready is the advance signal and stalls lose nothing.
//  aresetn (synchronous) clears valid bits and loads the floor with 16.
// ----------------------------------------------------------------------------
module dirac_energy_weighting import dew_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] energy_sample, [47:32] dirac_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] weighted_sample
    output logic        m_tuser,   // [0] saturated
    input  logic        cfg_wen,
    input  logic [14:0] cfg_wdata  // [14:0] magnitude_floor
);

    logic        adv;
    logic [14:0] floor_reg;
    mul_out_t    mul_out;
    div_out_t    div_out;
    sqrt_out_t   sqrt_out;

    logic        out_v_reg;
    logic [31:0] out_data_reg;
    logic        out_sat_reg;
    logic [31:0] res_next;
    logic        sat_next;

    // pipe moves when the output slot is free or being drained
    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= 15'd16;
        end else if (cfg_wen) begin
            floor_reg <= cfg_wdata;
        end
    end

    dew_mul u_mul (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (s_tvalid),
        .energy_sample   (s_tdata[31:0]),
        .dirac_sample    (s_tdata[47:32]),
        .magnitude_floor (floor_reg),
        .out             (mul_out)
    );

    dew_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in      (mul_out),
        .out     (div_out)
    );

    dew_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in      (div_out),
        .out     (sqrt_out)
    );

    // sign and clip: negative side reaches -2^31 unclipped
    always_comb begin
        sat_next = 1'b0;
        if (sqrt_out.neg) begin
            if (sqrt_out.root > 32'h8000_0000) begin
                res_next = 32'h8000_0000;
                sat_next = 1'b1;
            end else begin
                res_next = 32'd0 - sqrt_out.root;
            end
        end else begin
            if (sqrt_out.root > 32'h7FFF_FFFF) begin
                res_next = 32'h7FFF_FFFF;
                sat_next = 1'b1;
            end else begin
                res_next = sqrt_out.root;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= sqrt_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= res_next;
            out_sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ===== sim/dirac_energy_weighting_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirac_energy_weighting_test
// Self-checking bench: drives energy/dirac items with random idling on both
// sides, predicts each weighted sample with exact integer math and compares.
// ----------------------------------------------------------------------------
module dirac_energy_weighting_test;

    localparam int LATENCY = 68;

    typedef struct packed {
        logic [31:0] weighted;
        logic        sat;
    } weighted_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wen = 1'b0;
    logic [14:0] cfg_wdata = '0;

    // model copy of the floor register
    logic [14:0] floor_q = 15'd16;
    weighted_t   pending_q[$];
    int          mismatches = 0;
    int          unexpected = 0;
    bit          idle_on = 1'b1;

    always #4 aclk = ~aclk;

    dirac_energy_weighting DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic weighted_t weigh(logic [31:0] e, logic [15:0] d);
        weighted_t   r;
        logic [63:0] emag;
        logic [63:0] dmag;
        logic [63:0] fl;
        logic [63:0] m;
        logic [63:0] mag;
        emag = e[31] ? (64'h1_0000_0000 - {32'd0, e}) : {32'd0, e};
        dmag = d[15] ? (64'h1_0000 - {48'd0, d}) : {48'd0, d};
        fl   = (floor_q == 0) ? 64'd1 : {49'd0, floor_q};
        m    = (dmag > fl) ? dmag : fl;
        mag  = root64((64'd4 * dmag * dmag * emag) / m);
        r.sat = 1'b0;
        if (d[15]) begin
            if (mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
                r.sat = 1'b1;
            end
            r.weighted = 32'(64'h1_0000_0000 - mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                mag = 64'h7FFF_FFFF;
                r.sat = 1'b1;
            end
            r.weighted = mag[31:0];
        end
        return r;
    endfunction

    // leaves s_tvalid high; callers drop it before a pause
    task automatic send_item(logic [31:0] e, logic [15:0] d);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(weigh(e, d));
        @(negedge aclk);
    endtask

    // write the floor only with the pipe drained
    task automatic set_floor(logic [14:0] v);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        floor_q = v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [15:0] rand_dirac();
        case ($urandom_range(0, 5))
            0: return 16'h4000;         // +1.0
            1: return 16'hC000;         // -1.0
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 64)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int n);
        repeat (n) send_item($urandom, rand_dirac());
    endtask

    task automatic test_extremes();
        send_item(32'h7FFF_FFFF, 16'h7FFF);
        send_item(32'h8000_0000, 16'h8000);  // most negative energy, overflow
        send_item(32'h8000_0000, 16'h7FFF);
        send_item(32'h0000_0000, 16'h4000);
        send_item(32'h1234_5678, 16'h0000);  // zero dirac
        send_item(32'hFFFF_FFFF, 16'hFFFF);
        send_item(32'h0001_0000, 16'h4000);
        send_item(32'h0001_0000, 16'hC000);
        send_item(32'h0000_0001, 16'h0001);
        send_item(32'h7FFF_FFFF, 16'h0001);  // below floor
        send_item(32'h4000_0000, 16'h8000);  // lands near -2^23.5, no clip
        send_item(32'h2000_0000, 16'h8000);
    endtask

    task automatic test_floor_settings();
        logic [14:0] floors[5] = '{15'd0, 15'd1, 15'd32767, 15'd16384, 15'd16};
        foreach (floors[i]) begin
            set_floor(floors[i]);  // zero floor behaves as one
            send_item(32'h7FFF_FFFF, 16'h0001);
            send_item(32'h8000_0000, 16'hFFFF);
            send_item(32'h0001_0000, 16'h4000);
            random_items(80);
        end
    endtask

    task automatic test_random_floors();
        repeat (6) begin
            set_floor(15'($urandom));
            random_items(150);
        end
        set_floor(15'($urandom_range(0, 64)));
        random_items(200);
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        random_items(300);
    endtask

    // result side: random back-pressure bursts, none at the end
    initial begin
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        weighted_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("unexpected result %h sat %b", m_tdata, m_tuser);
            end else begin
                exp_r = pending_q.pop_front();
                if (m_tdata !== exp_r.weighted || m_tuser !== exp_r.sat) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp %h sat %b, got %h sat %b",
                                 exp_r.weighted, exp_r.sat, m_tdata, m_tuser);
                end
            end
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_floor_settings();
        test_random_floors();
        test_full_rate();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (mismatches == 0 && unexpected == 0 && pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
